@@ hdl/padded_number_digit_renderer_assert.svh @@
// Assertion macros used by the checker file of the digit renderer
`ifndef PADDED_NUMBER_DIGIT_RENDERER_ASSERT_SVH
`define PADDED_NUMBER_DIGIT_RENDERER_ASSERT_SVH

// same-cycle implication, off during reset
`define DNDR_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define DNDR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication, checked also while reset is asserted
`define DNDR_ASSERT_ALWAYS(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/dndr_pkg.sv @@
// Types, constants and font table of the digit renderer
package dndr_pkg;

  localparam int VALUE_W = 27;
  localparam int NUM_BCD = 9;
  localparam int BCD_W   = 4;
  localparam int TILE_W  = 8;
  localparam int FONT_W  = 15;

  typedef logic [NUM_BCD-1:0][BCD_W-1:0] bcd_vec_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONV,
    S_LOAD,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic       busy;
    logic [3:0] len;
  } bcd_stat_t;

  typedef struct packed {
    logic busy;
  } emit_stat_t;

  // 5x3 font: bit 5*col + row
  function automatic logic [FONT_W-1:0] font_bits(input logic [BCD_W-1:0] d);
    logic [FONT_W-1:0] b;
    case (d)
      4'd0:    b = 15'd32319;
      4'd1:    b = 15'd17393;
      4'd2:    b = 15'd24253;
      4'd3:    b = 15'd32437;
      4'd4:    b = 15'd31879;
      4'd5:    b = 15'd30391;
      4'd6:    b = 15'd29343;
      4'd7:    b = 15'd31905;
      4'd8:    b = 15'd32447;
      4'd9:    b = 15'd31911;
      default: b = '0;
    endcase
    return b;
  endfunction

endpackage

@@ hdl/dndr_bcd.sv @@
// Iterative binary to BCD converter, one shift-and-correct step per cycle
module dndr_bcd (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    start,
  input  logic [dndr_pkg::VALUE_W-1:0]            value,
  output dndr_pkg::bcd_vec_t                      digits,
  output dndr_pkg::bcd_stat_t                     stat
);
  import dndr_pkg::*;

  localparam int CNT_W = $clog2(VALUE_W + 1);

  logic [VALUE_W-1:0] bin_r, bin_nxt;
  bcd_vec_t           bcd_r, bcd_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  bcd_vec_t           adj;
  logic [3:0]         len;

  always_comb begin
    for (int i = 0; i < NUM_BCD; i++) begin
      adj[i] = (bcd_r[i] >= BCD_W'(5)) ? bcd_r[i] + BCD_W'(3) : bcd_r[i];
    end
  end

  always_comb begin
    bin_nxt = bin_r;
    bcd_nxt = bcd_r;
    cnt_nxt = cnt_r;
    if (start) begin
      bin_nxt = value;
      bcd_nxt = '0;
      cnt_nxt = CNT_W'(VALUE_W);
    end else if (cnt_r != '0) begin
      {bcd_nxt, bin_nxt} = {adj, bin_r} << 1;
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // digit count, at least one
  always_comb begin
    len = 4'd1;
    for (int i = 1; i < NUM_BCD; i++) begin
      if (bcd_r[i] != '0) len = 4'(i + 1);
    end
  end

  assign digits    = bcd_r;
  assign stat.busy = (cnt_r != '0);
  assign stat.len  = len;

endmodule

@@ hdl/dndr_emit.sv @@
// Glyph column sequencer with registered result stage
module dndr_emit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [3:0]                        num_glyphs,
  input  logic [3:0]                        len,
  input  dndr_pkg::bcd_vec_t                digits,
  input  logic [4:0]                        pad_digit,
  input  logic [dndr_pkg::TILE_W-1:0]       fg_tile,
  input  logic [dndr_pkg::TILE_W-1:0]       bg_tile,
  input  logic [7:0]                        origin_col,
  input  logic [7:0]                        origin_row,
  output dndr_pkg::emit_stat_t              stat,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [63:0]                       out_tdata,
  output logic                              out_tlast
);
  import dndr_pkg::*;

  logic             busy_r, busy_nxt;
  logic [3:0]       g_r, g_nxt;
  logic [1:0]       c_r, c_nxt;
  logic             vld_r, vld_nxt;
  logic [63:0]      data_r, data_nxt;
  logic             last_r, last_nxt;

  logic             free, fire, last_col;
  logic             blank_all, is_pad, pad_ok, glyph_ok;
  logic [3:0]       lead, didx;
  logic [BCD_W-1:0] glyph;
  logic [FONT_W-1:0] bits;
  logic [4:0]       col_bits;
  logic [8:0]       tcol;
  logic [4*TILE_W-1+TILE_W:0] rows;

  assign free     = !vld_r || out_tready;
  assign fire     = busy_r && free;
  assign last_col = (g_r == num_glyphs - 4'd1) && (c_r == 2'd2);

  always_comb begin
    blank_all = (len > num_glyphs);
    lead      = num_glyphs - len;
    is_pad    = (g_r < lead);
    pad_ok    = (pad_digit <= 5'd9);
    didx      = num_glyphs - 4'd1 - g_r;
    glyph     = is_pad ? pad_digit[BCD_W-1:0] : digits[didx];
    glyph_ok  = !blank_all && (!is_pad || pad_ok);
    bits      = glyph_ok ? font_bits(glyph) : '0;
    case (c_r)
      2'd0:    col_bits = bits[4:0];
      2'd1:    col_bits = bits[9:5];
      2'd2:    col_bits = bits[14:10];
      default: col_bits = '0;
    endcase
    for (int r = 0; r < 5; r++) begin
      rows[r*TILE_W +: TILE_W] = col_bits[r] ? fg_tile : bg_tile;
    end
    tcol = 9'(origin_col) + 9'({g_r, 2'b00}) + 9'(c_r);
  end

  always_comb begin
    busy_nxt = busy_r;
    g_nxt    = g_r;
    c_nxt    = c_r;
    data_nxt = data_r;
    last_nxt = last_r;
    vld_nxt  = out_tready ? 1'b0 : vld_r;
    if (start) begin
      busy_nxt = (num_glyphs != 4'd0);
      g_nxt    = '0;
      c_nxt    = '0;
    end else if (fire) begin
      vld_nxt  = 1'b1;
      data_nxt = {7'd0, rows, origin_row, tcol};
      last_nxt = last_col;
      if (last_col) begin
        busy_nxt = 1'b0;
      end else if (c_r == 2'd2) begin
        c_nxt = '0;
        g_nxt = g_r + 4'd1;
      end else begin
        c_nxt = c_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    g_r    <= g_nxt;
    c_r    <= c_nxt;
    data_r <= data_nxt;
    last_r <= last_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      vld_r  <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      vld_r  <= vld_nxt;
    end
  end

  assign stat.busy  = busy_r;
  assign out_tvalid = vld_r;
  assign out_tdata  = data_r;
  assign out_tlast  = last_r;

endmodule

@@ hdl/padded_number_digit_renderer.sv @@
// Top level of the padded decimal digit renderer
// Each accepted item is converted to decimal by a shift-and-add-3 unit that
// takes one bit of the 27-bit value per cycle, then the field is written one
// glyph column per cycle while the sink accepts, through a single output
// register: 3 results per glyph, last column flagged by out_tlast. With
// n = min(digit_count, MAX_DIGITS) glyphs, an item passes from its acceptance
// to the earliest next one through a start, the conversion steps, a check
// that the converter is done, a load, the 3n columns and a return to idle.
// Sink stalls add their length to the column phase. in_tready stays low from
// acceptance and rises once the emitter has cleared its busy flag and the
// state machine has returned to idle.
// Configuration is taken on any cycle with cfg_we high; write it only while
// the block is idle.
module padded_number_digit_renderer #(
  parameter int MAX_DIGITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // value[26:0], origin_col[34:27], origin_row[42:35]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // tile_col[8:0], tile_row[16:9], tile_r0..tile_r4[56:17]
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_wdata
);
  import dndr_pkg::*;

  localparam logic [1:0] REG_DIGIT_COUNT = 2'd0;
  localparam logic [1:0] REG_PAD_DIGIT   = 2'd1;
  localparam logic [1:0] REG_FG_TILE     = 2'd2;
  localparam logic [1:0] REG_BG_TILE     = 2'd3;

  state_t      state_r, state_nxt;
  logic [3:0]  dcount_r;
  logic [4:0]  pad_r;
  logic [7:0]  fg_r, bg_r;
  logic [7:0]  ocol_r, orow_r;
  logic [3:0]  num_glyphs;
  logic        bcd_start, emit_start, accept;
  bcd_vec_t    digits;
  bcd_stat_t   bcd_stat;
  emit_stat_t  emit_stat;

  assign num_glyphs = (dcount_r > 4'(MAX_DIGITS)) ? 4'(MAX_DIGITS) : dcount_r;
  assign accept     = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (accept) begin
      ocol_r <= in_tdata[34:27];
      orow_r <= in_tdata[42:35];
    end
    if (!rst_n) begin
      state_r  <= S_IDLE;
      dcount_r <= 4'd3;
      pad_r    <= '0;
      fg_r     <= '0;
      bg_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_DIGIT_COUNT: dcount_r <= cfg_wdata[3:0];
          REG_PAD_DIGIT:   pad_r    <= cfg_wdata[4:0];
          REG_FG_TILE:     fg_r     <= cfg_wdata;
          REG_BG_TILE:     bg_r     <= cfg_wdata;
          default:         ;
        endcase
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (accept) state_nxt = S_CONV;
      S_CONV:  if (!bcd_stat.busy) state_nxt = S_LOAD;
      S_LOAD:  state_nxt = S_EMIT;
      S_EMIT:  if (!emit_stat.busy) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_tready  = (state_r == S_IDLE);
    bcd_start  = (state_r == S_IDLE) && in_tvalid;
    emit_start = (state_r == S_LOAD);
  end

  dndr_bcd u_bcd (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (bcd_start),
    .value  (in_tdata[VALUE_W-1:0]),
    .digits (digits),
    .stat   (bcd_stat)
  );

  dndr_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (emit_start),
    .num_glyphs (num_glyphs),
    .len        (bcd_stat.len),
    .digits     (digits),
    .pad_digit  (pad_r),
    .fg_tile    (fg_r),
    .bg_tile    (bg_r),
    .origin_col (ocol_r),
    .origin_row (orow_r),
    .stat       (emit_stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

@@ hdl/dndr_checker.sv @@
// Port-level checker for the digit renderer and its bind
`include "padded_number_digit_renderer_assert.svh"

module dndr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic        out_tlast
);

  `DNDR_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_tvalid && in_tready, !in_tready, "ready high right after an accepted item")
  `DNDR_ASSERT_NOW(a_idle_only_last, clk, rst_n, in_tready && out_tvalid, out_tlast, "idle while a non-final column is pending")
  `DNDR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast), "stalled result changed")
  `DNDR_ASSERT_ALWAYS(a_reset_clears, clk, !rst_n, !out_tvalid, "result valid after reset")

endmodule

bind padded_number_digit_renderer dndr_checker u_dndr_checker (.*);

@@ tb/tb_padded_number_digit_renderer.sv @@
// Self-checking testbench for the padded decimal digit renderer
module tb_padded_number_digit_renderer;
  import dndr_pkg::*;

  localparam int MAX_DIGITS = 8;
  localparam int DRAIN_CYCLES = 120;
  localparam int SINK_HOLD_CYCLES = 400;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_ITEMS = 15;

  localparam logic [1:0] REG_DIGIT_COUNT = 2'd0;
  localparam logic [1:0] REG_PAD_DIGIT   = 2'd1;
  localparam logic [1:0] REG_FG_TILE     = 2'd2;
  localparam logic [1:0] REG_BG_TILE     = 2'd3;

  localparam logic [4:0] PAD_BLANK = 5'h1F;

  // digit d at [d]; bit 5*col + row
  localparam logic [9:0][14:0] GLYPH_FONT = {
    15'd31911, 15'd32447, 15'd31905, 15'd29343, 15'd30391,
    15'd31879, 15'd32437, 15'd24253, 15'd17393, 15'd32319
  };

  typedef struct packed {
    logic [8:0]      col;
    logic [7:0]      row;
    logic [4:0][7:0] codes;
    logic            last;
  } glyph_col_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic        out_tlast;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [7:0]  cfg_wdata = '0;

  // register copies, reset values
  logic [3:0] count_reg = 4'd3;
  logic [4:0] pad_reg = 5'd0;
  logic [7:0] fg_reg = 8'd0;
  logic [7:0] bg_reg = 8'd0;

  logic [47:0] item_q[$];
  glyph_col_t  column_q[$];

  int   mismatches = 0;
  int   items_taken = 0;
  int   columns_seen = 0;
  int   settings_used = 0;
  logic no_idle = 1'b0;
  logic sink_hold_req = 1'b0;
  int   sink_hold_cnt = 0;

  padded_number_digit_renderer #(.MAX_DIGITS(MAX_DIGITS)) i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("padded_number_digit_renderer: mismatch");
    $finish;
  end

  function automatic void render_field(input logic [26:0] value, input logic [7:0] ocol,
                                       input logic [7:0] orow);
    logic [3:0]  digs [0:8];
    logic [26:0] v;
    logic [14:0] bits;
    glyph_col_t  e;
    int len, n, lead, glyph, g, c, r;
    n = (count_reg > MAX_DIGITS) ? MAX_DIGITS : int'(count_reg);
    v = value;
    digs[0] = 4'(v % 10);
    v = v / 10;
    len = 1;
    while (v != 0 && len < 9) begin
      digs[len] = 4'(v % 10);
      v = v / 10;
      len++;
    end
    lead = n - len;
    for (g = 0; g < n; g++) begin
      if (len > n)
        glyph = -1;
      else if (g < lead)
        glyph = (pad_reg <= 5'd9) ? int'(pad_reg) : -1;
      else
        glyph = int'(digs[len - 1 - (g - lead)]);
      bits = (glyph >= 0) ? GLYPH_FONT[glyph] : '0;
      for (c = 0; c < 3; c++) begin
        e.col = 9'(int'(ocol) + 4 * g + c);
        e.row = orow;
        for (r = 0; r < 5; r++)
          e.codes[r] = bits[5 * c + r] ? fg_reg : bg_reg;
        e.last = (g == n - 1) && (c == 2);
        column_q.push_back(e);
      end
    end
  endfunction

  function automatic void note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10)
      $display("ERROR: %s", msg);
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        render_field(in_tdata[26:0], in_tdata[34:27], in_tdata[42:35]);
        items_taken++;
      end
      if (!in_tvalid || in_tready) begin
        if (item_q.size() != 0 && (no_idle || $urandom_range(99) >= 6)) begin
          in_tdata <= item_q.pop_front();
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // long sink hold-off
  always @(posedge clk) begin
    if (!rst_n)
      sink_hold_cnt <= 0;
    else if (sink_hold_req)
      sink_hold_cnt <= SINK_HOLD_CYCLES;
    else if (sink_hold_cnt != 0)
      sink_hold_cnt <= sink_hold_cnt - 1;
  end

  // monitor
  always @(posedge clk) begin
    glyph_col_t got, exp_col;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = {out_tdata[8:0], out_tdata[16:9], out_tdata[56:17], out_tlast};
        columns_seen++;
        if (column_q.size() == 0) begin
          note_mismatch($sformatf("unexpected column col=%0d row=%0d codes=%h last=%b",
                                  got.col, got.row, got.codes, got.last));
        end else begin
          exp_col = column_q.pop_front();
          if (got !== exp_col)
            note_mismatch($sformatf(
              "col %0d/%0d row %0d/%0d codes %h/%h last %b/%b (expected/actual)",
              exp_col.col, got.col, exp_col.row, got.row, exp_col.codes, got.codes,
              exp_col.last, got.last));
        end
      end
      out_tready <= (sink_hold_cnt == 0) && (no_idle || $urandom_range(99) >= 6);
    end
  end

  task automatic wait_drained();
    @(negedge clk);
    while (item_q.size() != 0 || in_tvalid || column_q.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [7:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_DIGIT_COUNT: count_reg = data[3:0];
      REG_PAD_DIGIT:   pad_reg = data[4:0];
      REG_FG_TILE:     fg_reg = data;
      REG_BG_TILE:     bg_reg = data;
      default:         ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_regs(input logic [3:0] cnt, input logic [4:0] pad,
                          input logic [7:0] fg, input logic [7:0] bg);
    wait_drained();
    cfg_write(REG_DIGIT_COUNT, {4'd0, cnt});
    cfg_write(REG_PAD_DIGIT, {3'd0, pad});
    cfg_write(REG_FG_TILE, fg);
    cfg_write(REG_BG_TILE, bg);
    @(negedge clk);
    settings_used++;
  endtask

  task automatic send(input logic [26:0] value, input logic [7:0] ocol,
                      input logic [7:0] orow);
    item_q.push_back({5'd0, orow, ocol, value});
  endtask

  function automatic logic [26:0] random_value();
    int k, lo, hi;
    if ($urandom_range(7) == 0)
      return 27'($urandom);
    k = $urandom_range(9, 1);
    lo = (k == 1) ? 0 : 10 ** (k - 1);
    hi = 10 ** k - 1;
    if (hi > 134217727)
      hi = 134217727;
    return 27'($urandom_range(hi, lo));
  endfunction

  initial begin
    int ph, k, sel;
    logic [3:0] cnt;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset register values
    settings_used++;
    send(27'd0, 8'd0, 8'd0);
    send(27'd999, 8'd255, 8'd255);
    send(27'd1000, 8'd17, 8'd3);

    set_regs(4'd8, 5'd0, 8'hFF, 8'h00);
    send(27'd0, 8'd10, 8'd20);
    send(27'd99999999, 8'd255, 8'd0);
    send(27'd12345678, 8'd0, 8'd255);
    send(27'd123456789, 8'd100, 8'd100);
    send(27'h7FFFFFF, 8'hAA, 8'h55);
    send(27'd5, 8'h55, 8'hAA);

    set_regs(4'd1, PAD_BLANK, 8'hA5, 8'h5A);
    send(27'd0, 8'd1, 8'd2);
    send(27'd9, 8'd3, 8'd4);
    send(27'd10, 8'd5, 8'd6);

    set_regs(4'd0, 5'd9, 8'h11, 8'h22);
    send(27'd42, 8'd7, 8'd8);
    send(27'd0, 8'd9, 8'd10);

    set_regs(4'd15, 5'd12, 8'h00, 8'hFF);
    send(27'd42, 8'd250, 8'd11);
    send(27'd0, 8'd12, 8'd13);

    set_regs(4'd5, 5'h10, 8'h3C, 8'hC3);
    send(27'd7, 8'd14, 8'd15);
    send(27'd314, 8'd16, 8'd17);

    set_regs(4'd4, 5'd9, 8'd1, 8'd2);
    send(27'd67, 8'd18, 8'd19);

    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      sel = $urandom_range(9);
      if (sel == 0)
        cnt = 4'd0;
      else if (sel == 1)
        cnt = 4'($urandom_range(15, 9));
      else
        cnt = 4'($urandom_range(8, 1));
      set_regs(cnt, 5'($urandom_range(31)), 8'($urandom_range(255)),
               8'($urandom_range(255)));
      no_idle = (ph == 4);
      if (ph == 7) begin
        sink_hold_req = 1'b1;
        @(negedge clk);
        sink_hold_req = 1'b0;
      end
      for (k = 0; k < PHASE_ITEMS; k++) begin
        if (ph == 9 && k == PHASE_ITEMS / 2) begin
          // sender waits for every outstanding column
          @(negedge clk);
          while (item_q.size() != 0 || in_tvalid || column_q.size() != 0)
            @(negedge clk);
        end
        send(random_value(), 8'($urandom_range(255)), 8'($urandom_range(255)));
      end
    end

    wait_drained();
    no_idle = 1'b0;
    $display("Covered %0d items, %0d tile columns, %0d register settings",
             items_taken, columns_seen, settings_used);
    $display("Included blank padding, field overflow, zero and saturated digit counts");
    if (mismatches == 0)
      $display("padded_number_digit_renderer: match");
    else
      $display("padded_number_digit_renderer: mismatch");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/dndr_pkg.sv
hdl/dndr_bcd.sv
hdl/dndr_emit.sv
hdl/padded_number_digit_renderer.sv
hdl/dndr_checker.sv
tb/tb_padded_number_digit_renderer.sv
